// File: hw/rtl/gtbp_pkg.sv
// shared constants, request types and counter helpers for the branch predictor
package gtbp_pkg;

  // history and index widths
  localparam int GHB = 13;
  localparam int LHB = 11;
  localparam int AIB = 10;

  localparam int GSIZE = 1 << GHB;
  localparam int LSIZE = 1 << LHB;
  localparam int ASIZE = 1 << AIB;

  // address bits the back end ever looks at
  localparam int ABITS = (GHB > AIB) ? GHB : AIB;

  // clearing pass covers the deepest table
  localparam int CLR_DEPTH = (GSIZE > LSIZE) ? ((GSIZE > ASIZE) ? GSIZE : ASIZE)
                                             : ((LSIZE > ASIZE) ? LSIZE : ASIZE);
  localparam int CLR_BITS = $clog2(CLR_DEPTH);

  // request queue between front and back
  localparam int QBITS = 2;
  localparam int QDEPTH = 1 << QBITS;

  // counter values
  localparam logic [1:0] CTR_MIN = 2'd0;
  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [1:0] CTR_WEAK_GLOBAL = 2'd2;

  typedef enum logic {
    KIND_PREDICT = 1'b0,
    KIND_TRAIN   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    MODE_STATIC     = 2'd0,
    MODE_GSHARE     = 2'd1,
    MODE_TOURNAMENT = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [ABITS-1:0]  addr;
    logic              taken;
  } req_t;

  // front to back
  typedef struct packed {
    logic empty;
    req_t req;
  } fb_t;

  // back to front
  typedef struct packed {
    logic pop;
    logic clearing;
  } bf_t;

  // saturating 2-bit counter step
  function automatic logic [1:0] ctr_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/gtbp_ram.sv
// generic single write port ram with registered read
module gtbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/gtbp_front.sv
// front end: takes requests, classifies them and queues them for the back end
module gtbp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic           in_kind,
  input  logic [31:0]    in_branch_address,
  input  logic           in_taken_outcome,
  output gtbp_pkg::fb_t  fb,
  input  gtbp_pkg::bf_t  bf
);

  gtbp_pkg::req_t               q_r [gtbp_pkg::QDEPTH];
  logic [gtbp_pkg::QBITS-1:0]   wptr_r;
  logic [gtbp_pkg::QBITS-1:0]   rptr_r;
  logic [gtbp_pkg::QBITS:0]     cnt_r;
  gtbp_pkg::req_t               req;
  logic                         push_ok;
  logic                         pop_ok;

  always_comb begin
    req.kind  = in_kind ? gtbp_pkg::KIND_TRAIN : gtbp_pkg::KIND_PREDICT;
    req.addr  = in_branch_address[gtbp_pkg::ABITS-1:0];
    req.taken = in_taken_outcome;
  end

  // no requests while the tables are being cleared
  assign in_full  = (cnt_r == (gtbp_pkg::QBITS+1)'(gtbp_pkg::QDEPTH)) || bf.clearing;
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = bf.pop && (cnt_r != '0);
  assign fb.empty = (cnt_r == '0);
  assign fb.req   = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_ok) begin
        q_r[wptr_r] <= req;
        wptr_r      <= wptr_r + 1'b1;
      end
      if (pop_ok) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/gtbp_back.sv
// back end: table reads, prediction, training updates and the result register
module gtbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     mode,
  input  gtbp_pkg::fb_t  fb,
  output gtbp_pkg::bf_t  bf,
  output logic           res_valid,
  output logic           res_taken,
  input  logic           res_pop
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2
  } state_t;

  localparam int GHB = gtbp_pkg::GHB;
  localparam int LHB = gtbp_pkg::LHB;
  localparam int AIB = gtbp_pkg::AIB;
  localparam int CB  = gtbp_pkg::CLR_BITS;

  state_t                state_r, state_nxt;
  gtbp_pkg::req_t        req_r;
  logic [GHB-1:0]        ghist_r;
  logic                  clr_r;
  logic [CB-1:0]         clr_idx_r;
  logic                  res_valid_r;
  logic                  res_taken_r;

  logic                  start;
  logic                  fin;
  logic                  is_train;
  logic                  train_fire;
  logic                  res_load;
  logic                  pred;
  logic                  local_ok;
  logic                  global_ok;
  logic [1:0]            cho_nxt;
  logic [GHB:0]          gh_shift;
  logic [LHB:0]          lh_shift;
  logic [GHB-1:0]        gsh_ridx;
  logic [GHB-1:0]        gsh_widx;
  logic                  clr_g;
  logic                  clr_l;
  logic                  clr_a;
  logic                  clr_last;

  logic [1:0]            gsh_rd, glb_rd, cho_rd, loc_rd;
  logic [LHB-1:0]        lh_rd;
  logic                  g_we, l_we, a_we;
  logic [GHB-1:0]        gsh_waddr, g_waddr;
  logic [LHB-1:0]        l_waddr;
  logic [AIB-1:0]        a_waddr;
  logic [1:0]            gsh_wdata, glb_wdata, cho_wdata, loc_wdata;
  logic [LHB-1:0]        lh_wdata;

  assign start    = (state_r == S_IDLE) && !clr_r && !fb.empty;
  assign fin      = (state_r == S_RD2);
  assign is_train = (req_r.kind == gtbp_pkg::KIND_TRAIN);
  assign train_fire = fin && is_train;
  assign res_load = fin && !is_train && (!res_valid_r || res_pop);

  assign gsh_ridx = fb.req.addr[GHB-1:0] ^ ghist_r;
  assign gsh_widx = req_r.addr[GHB-1:0] ^ ghist_r;

  // clearing pass range per table
  assign clr_g    = {1'b0, clr_idx_r} < (CB+1)'(gtbp_pkg::GSIZE);
  assign clr_l    = {1'b0, clr_idx_r} < (CB+1)'(gtbp_pkg::LSIZE);
  assign clr_a    = {1'b0, clr_idx_r} < (CB+1)'(gtbp_pkg::ASIZE);
  assign clr_last = (clr_idx_r == CB'(gtbp_pkg::CLR_DEPTH - 1));

  always_comb begin
    unique case (mode)
      gtbp_pkg::MODE_STATIC:     pred = 1'b1;
      gtbp_pkg::MODE_GSHARE:     pred = gsh_rd[1];
      gtbp_pkg::MODE_TOURNAMENT: pred = cho_rd[1] ? glb_rd[1] : loc_rd[1];
      default:                   pred = 1'b0;
    endcase
  end

  // choice moves toward the side that alone was right
  always_comb begin
    local_ok  = (loc_rd[1] == req_r.taken);
    global_ok = (glb_rd[1] == req_r.taken);
    if (local_ok && !global_ok) begin
      cho_nxt = gtbp_pkg::ctr_move(cho_rd, 1'b0);
    end else if (!local_ok && global_ok) begin
      cho_nxt = gtbp_pkg::ctr_move(cho_rd, 1'b1);
    end else begin
      cho_nxt = cho_rd;
    end
  end

  assign gh_shift = {ghist_r, req_r.taken};
  assign lh_shift = {lh_rd, req_r.taken};

  always_comb begin
    g_we      = clr_r ? clr_g : train_fire;
    l_we      = clr_r ? clr_l : train_fire;
    a_we      = clr_r ? clr_a : train_fire;
    g_waddr   = clr_r ? clr_idx_r[GHB-1:0] : ghist_r;
    gsh_waddr = clr_r ? clr_idx_r[GHB-1:0] : gsh_widx;
    l_waddr   = clr_r ? clr_idx_r[LHB-1:0] : lh_rd;
    a_waddr   = clr_r ? clr_idx_r[AIB-1:0] : req_r.addr[AIB-1:0];
    gsh_wdata = clr_r ? gtbp_pkg::CTR_WEAK_NT : gtbp_pkg::ctr_move(gsh_rd, req_r.taken);
    glb_wdata = clr_r ? gtbp_pkg::CTR_WEAK_NT : gtbp_pkg::ctr_move(glb_rd, req_r.taken);
    loc_wdata = clr_r ? gtbp_pkg::CTR_WEAK_NT : gtbp_pkg::ctr_move(loc_rd, req_r.taken);
    cho_wdata = clr_r ? gtbp_pkg::CTR_WEAK_GLOBAL : cho_nxt;
    lh_wdata  = clr_r ? '0 : lh_shift[LHB-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  if (train_fire || res_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  gtbp_ram #(.WIDTH(2), .DEPTH(gtbp_pkg::GSIZE)) u_gsh (
    .clk(clk), .we(g_we), .waddr(gsh_waddr), .wdata(gsh_wdata),
    .re(start), .raddr(gsh_ridx), .rdata(gsh_rd)
  );

  gtbp_ram #(.WIDTH(2), .DEPTH(gtbp_pkg::GSIZE)) u_glb (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(glb_wdata),
    .re(start), .raddr(ghist_r), .rdata(glb_rd)
  );

  gtbp_ram #(.WIDTH(2), .DEPTH(gtbp_pkg::GSIZE)) u_cho (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(cho_wdata),
    .re(start), .raddr(ghist_r), .rdata(cho_rd)
  );

  gtbp_ram #(.WIDTH(LHB), .DEPTH(gtbp_pkg::ASIZE)) u_lh (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(lh_wdata),
    .re(start), .raddr(fb.req.addr[AIB-1:0]), .rdata(lh_rd)
  );

  // local counter index comes out of the local history read
  gtbp_ram #(.WIDTH(2), .DEPTH(gtbp_pkg::LSIZE)) u_loc (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(loc_wdata),
    .re(state_r == S_RD1), .raddr(lh_rd), .rdata(loc_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ghist_r     <= '0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        req_r <= fb.req;
      end
      if (train_fire) begin
        ghist_r <= gh_shift[GHB-1:0];
      end
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_last) clr_r <= 1'b0;
      end
      if (res_load) begin
        res_valid_r <= 1'b1;
        res_taken_r <= pred;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign bf.pop      = start;
  assign bf.clearing = clr_r;
  assign res_valid   = res_valid_r;
  assign res_taken   = res_taken_r;

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !start && !train_fire && !res_load)
    else $error("request handled during clearing pass");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !fb.empty)
    else $error("pop from empty request queue");

  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!res_valid_r || res_pop))
    else $error("result register overwritten");

  a_ghist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !train_fire |=> $stable(ghist_r))
    else $error("global history moved without training");

endmodule

// File: hw/rtl/gshare_tournament_branch_predictor_core.sv
// top level of the gshare / tournament branch predictor
// back end: takes one request at a time, as the local history ram read and then the dependent
//   local counter ram read must finish, and a predict waits while the result register is full;
//   a 4-entry request queue absorbs bursts
// reset: synchronous active low; mode returns to gshare and a clearing pass over the 8192
//   entries of the deepest table (one entry per cycle) follows, with in_full held high throughout
module gshare_tournament_branch_predictor_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_kind,
  input  logic [31:0] in_branch_address,
  input  logic        in_taken_outcome,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_predict_taken,
  // mode register
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  gtbp_pkg::fb_t fb;
  gtbp_pkg::bf_t bf;
  logic [1:0]    mode_r;
  logic          res_valid;

  // mode register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gtbp_pkg::MODE_GSHARE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // front end: request queue, keeps accepting while the back end works
  gtbp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_branch_address (in_branch_address),
    .in_taken_outcome  (in_taken_outcome),
    .fb                (fb),
    .bf                (bf)
  );

  // back end: table lookups, training and the result register
  gtbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .fb        (fb),
    .bf        (bf),
    .res_valid (res_valid),
    .res_taken (out_predict_taken),
    .res_pop   (out_pop && res_valid)
  );

  assign out_empty = !res_valid;

endmodule

// File: bench/tb.sv
// testbench for the gshare / tournament branch predictor core
`timescale 1ns / 100ps

module tb;
  import gtbp_pkg::*;

  // mode 3 has no predictor behind it and always answers not taken
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // no handshake on either side for this many cycles ends the run;
  // covers the clearing pass over the deepest table after reset with plenty to spare
  localparam int WATCHDOG_LIMIT = 40000;

  // 4-entry request queue plus a back end that steps S_IDLE, S_RD1, S_RD2 per request: trains
  // still in flight after the last predict result are gone well within this
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_kind = KIND_PREDICT;
  logic [31:0] in_branch_address = '0;
  logic        in_taken_outcome = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_predict_taken;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int fail_count = 0;
  int stall_cycles = 0;

  // predictor shadow state, kept in step with every accepted request
  logic [1:0]     mode_q;
  logic [GHB-1:0] ghist_q;
  logic [1:0]     gshare_ctr [GSIZE];
  logic [1:0]     global_ctr [GSIZE];
  logic [1:0]     choice_ctr [GSIZE];
  logic [1:0]     local_ctr  [LSIZE];
  logic [LHB-1:0] local_hist [ASIZE];

  // predicted directions still owed by the block, oldest first
  logic expected_dir_q [$];
  logic exp_dir;

  gshare_tournament_branch_predictor_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_branch_address (in_branch_address),
    .in_taken_outcome  (in_taken_outcome),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_predict_taken (out_predict_taken),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // saturating 2-bit counter, moves toward the given direction
  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  // direction a predict request gets from the current shadow state
  function automatic logic predict_direction(logic [31:0] addr);
    logic [GHB-1:0] gidx;
    logic [LHB-1:0] lh;
    gidx = addr[GHB-1:0] ^ ghist_q;
    lh = local_hist[addr[AIB-1:0]];
    case (mode_q)
      MODE_STATIC:     return 1'b1;
      MODE_GSHARE:     return gshare_ctr[gidx][1];
      MODE_TOURNAMENT: return choice_ctr[ghist_q][1] ? global_ctr[ghist_q][1]
                                                     : local_ctr[lh][1];
      default:         return 1'b0;
    endcase
  endfunction

  // train request: every table moves whatever the mode, all reads from the old state
  task automatic train_tables(logic [31:0] addr, logic taken);
    logic [GHB-1:0] gidx;
    logic [AIB-1:0] aidx;
    logic [LHB-1:0] lh;
    logic           loc_ok;
    logic           glb_ok;
    gidx = addr[GHB-1:0] ^ ghist_q;
    aidx = addr[AIB-1:0];
    lh = local_hist[aidx];
    loc_ok = (local_ctr[lh][1] == taken);
    glb_ok = (global_ctr[ghist_q][1] == taken);
    // choice counter leans toward whichever side alone got it right
    if (loc_ok && !glb_ok) begin
      choice_ctr[ghist_q] = sat_step(choice_ctr[ghist_q], 1'b0);
    end else if (!loc_ok && glb_ok) begin
      choice_ctr[ghist_q] = sat_step(choice_ctr[ghist_q], 1'b1);
    end
    gshare_ctr[gidx]    = sat_step(gshare_ctr[gidx], taken);
    local_ctr[lh]       = sat_step(local_ctr[lh], taken);
    global_ctr[ghist_q] = sat_step(global_ctr[ghist_q], taken);
    // histories shift last, the tables above were indexed by the old ones
    local_hist[aidx] = {lh[LHB-2:0], taken};
    ghist_q = {ghist_q[GHB-2:0], taken};
  endtask

  // sends one request and waits for its handshake; called and returning at a rising edge.
  // in_push is left high so a following request goes out back to back
  task automatic send_req(kind_t kind, logic [31:0] addr, logic taken);
    // sender gap, drawn cycle by cycle
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_kind           <= kind;
    in_branch_address <= addr;
    in_taken_outcome  <= taken;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    // accepted at this edge: bring the shadow state along
    if (kind == KIND_PREDICT) begin
      expected_dir_q.push_back(predict_direction(addr));
    end else begin
      train_tables(addr, taken);
    end
  endtask

  // stop sending, wait for every owed result, then let trailing trains finish
  task automatic settle();
    in_push <= 1'b0;
    while (expected_dir_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mode register write, only ever done with the block idle
  task automatic write_predictor_mode(logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q = m;
    @(posedge clk);
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // out of reset: gshare mode, all counters weakly not taken
  task automatic test_reset_defaults();
    send_req(KIND_PREDICT, 32'h0000_0000, 1'b0);
    send_req(KIND_PREDICT, 32'hFFFF_FFFF, 1'b1);
    settle();
  endtask

  // gshare counters trained up on one branch and down on another, with a predict after each run
  task automatic test_gshare_training();
    send_req(KIND_TRAIN, 32'h0000_1234, 1'b1);
    send_req(KIND_TRAIN, 32'h0000_1234, 1'b1);
    send_req(KIND_TRAIN, 32'h0000_1234, 1'b1);
    send_req(KIND_PREDICT, 32'h0000_1234, 1'b0);
    send_req(KIND_TRAIN, 32'hFFFF_FFFF, 1'b0);
    send_req(KIND_TRAIN, 32'hFFFF_FFFF, 1'b0);
    send_req(KIND_PREDICT, 32'hFFFF_FFFF, 1'b1);
    settle();
  endtask

  // static mode: always taken, outcome bit on a predict request is ignored
  task automatic test_static_mode();
    write_predictor_mode(MODE_STATIC);
    send_req(KIND_PREDICT, 32'h8000_0000, 1'b0);
    send_req(KIND_PREDICT, 32'h7FFF_FFFF, 1'b1);
    send_req(KIND_TRAIN, 32'h8000_0000, 1'b0);
    settle();
  endtask

  // tournament: local history fills on one branch, choice counter gets pushed around
  task automatic test_tournament_mode();
    write_predictor_mode(MODE_TOURNAMENT);
    send_req(KIND_TRAIN, 32'h0000_03FF, 1'b1);
    send_req(KIND_TRAIN, 32'h0000_03FF, 1'b1);
    send_req(KIND_TRAIN, 32'h0000_03FF, 1'b1);
    send_req(KIND_TRAIN, 32'h0000_03FF, 1'b1);
    send_req(KIND_PREDICT, 32'h0000_03FF, 1'b0);
    send_req(KIND_PREDICT, 32'h0001_03FF, 1'b0);
    send_req(KIND_TRAIN, 32'h0000_03FF, 1'b0);
    send_req(KIND_PREDICT, 32'h0000_03FF, 1'b1);
    settle();
  endtask

  // unused mode value: predicts not taken, training still updates every table
  task automatic test_unused_mode();
    write_predictor_mode(MODE_UNUSED);
    send_req(KIND_PREDICT, 32'h0000_1234, 1'b1);
    send_req(KIND_TRAIN, 32'h0000_1234, 1'b1);
    send_req(KIND_PREDICT, 32'h0000_1234, 1'b1);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly predict then train pairs on a small set of hot
  // branches with a per-branch bias, so counters saturate and histories fill;
  // the rest is loose requests at any address
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int s_pct, int r_pct, int n_reqs, logic [1:0] m);
    logic [31:0] hot_addr [8];
    logic        hot_bias [8];
    int          sent;
    int          k;
    write_predictor_mode(m);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    foreach (hot_addr[j]) begin
      hot_addr[j] = $urandom;
      hot_bias[j] = 1'($urandom_range(1));
    end
    // pairs of hot branches share a local history slot
    for (int j = 1; j < 8; j += 2) hot_addr[j][AIB-1:0] = hot_addr[j-1][AIB-1:0];
    sent = 0;
    while (sent < n_reqs) begin
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(7);
        send_req(KIND_PREDICT, hot_addr[k], 1'($urandom_range(1)));
        send_req(KIND_TRAIN, hot_addr[k],
                 ($urandom_range(99) < 85) ? hot_bias[k] : !hot_bias[k]);
        sent += 2;
      end else begin
        send_req(kind_t'(1'($urandom_range(1))), $urandom, 1'($urandom_range(1)));
        sent++;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random pop, in-order check against the owed directions
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_pop <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (expected_dir_q.size() == 0) begin
        note_failure($sformatf("unexpected result: predict_taken=%0b", out_predict_taken));
      end else begin
        exp_dir = expected_dir_q.pop_front();
        if (out_predict_taken !== exp_dir) begin
          note_failure($sformatf("predict_taken mismatch: expected %0b, got %0b",
                                 exp_dir, out_predict_taken));
        end
      end
    end
  end

  // watchdog: cycles without any handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // shadow state matches the block's reset values
    mode_q = MODE_GSHARE;
    ghist_q = '0;
    foreach (gshare_ctr[j]) gshare_ctr[j] = CTR_WEAK_NT;
    foreach (global_ctr[j]) global_ctr[j] = CTR_WEAK_NT;
    foreach (choice_ctr[j]) choice_ctr[j] = CTR_WEAK_GLOBAL;
    foreach (local_ctr[j]) local_ctr[j] = CTR_WEAK_NT;
    foreach (local_hist[j]) local_hist[j] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with the first idle mix: sender 29%, receiver 78%
    send_idle_pct = 29;
    recv_idle_pct = 78;
    test_reset_defaults();
    test_gshare_training();
    test_static_mode();
    test_tournament_mode();
    test_unused_mode();

    test_random_traffic(29, 78, 200, MODE_TOURNAMENT);
    test_random_traffic(78, 29, 200, MODE_GSHARE);
    // no idling from here on, sweeping the unused and static modes, then tournament again
    test_random_traffic(0, 0, 70, MODE_UNUSED);
    test_random_traffic(0, 0, 70, MODE_STATIC);
    test_random_traffic(0, 0, 70, MODE_TOURNAMENT);

    if (fail_count == 0 && expected_dir_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/gtbp_pkg.sv
hw/rtl/gtbp_ram.sv
hw/rtl/gtbp_front.sv
hw/rtl/gtbp_back.sv
hw/rtl/gshare_tournament_branch_predictor_core.sv
bench/tb.sv
